@@ rtl/core/cea_pkg.sv @@
// Shared constants, types and tables of the covariance error ellipse pipeline.
package cea_pkg;

    localparam int SQRT_W     = 64;  // radicand and partial root width
    localparam int SQRT_STEPS = 32;  // one result bit per cell
    localparam int CORDIC_W   = 37;  // x/y width incl. CORDIC gain
    localparam int ANGLE_W    = 21;  // angle accumulator, 2^-16 rad units
    localparam int YAW_W      = 15;  // Q2.13 output angle
    localparam int NUM_W      = 63;  // lateral numerator, never negative
    localparam int DEN_W      = 29;  // lateral denominator
    localparam int QUO_W      = 64;  // lateral quotient, wraps at 64 bits

    localparam logic signed [ANGLE_W-1:0] PI_Q16    = 21'sd205887;
    localparam logic signed [ANGLE_W-1:0] YAW_LIMIT = 21'sd12868;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ANGLE_W-1:0]  z;
        logic                       byp;  // axis-aligned vector, angle already final
    } cordic_t;

    // atan(2^-i) in 2^-16 rad units
    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/cea_sqrt_cell.sv @@
// One restoring square root step: decides one result bit and registers it.
module cea_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [cea_pkg::SQRT_W-1:0]   rad_in,
    input  logic [cea_pkg::SQRT_W-1:0]   root_in,
    output logic [cea_pkg::SQRT_W-1:0]   rad_out,
    output logic [cea_pkg::SQRT_W-1:0]   root_out
);
    localparam int W = cea_pkg::SQRT_W;
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * STEP);

    logic [W-1:0] trial;
    logic [W-1:0] rad_next;
    logic [W-1:0] root_next;
    logic [W-1:0] rad_reg;
    logic [W-1:0] root_reg;

    always_comb
    begin
        trial = root_in + BIT;
        if (rad_in >= trial)
        begin
            rad_next  = rad_in - trial;
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            rad_next  = rad_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign root_out = root_reg;

endmodule

@@ rtl/core/cea_div_cell.sv @@
// One restoring division step: brings down one dividend bit, yields one quotient bit.
module cea_div_cell #(
    parameter int J = 0  // dividend bit position counted from the top
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [cea_pkg::NUM_W-1:0]   num_in,
    input  logic [cea_pkg::DEN_W-1:0]   den_in,
    input  logic [cea_pkg::DEN_W-1:0]   rem_in,
    input  logic [cea_pkg::QUO_W-1:0]   quo_in,
    output logic [cea_pkg::NUM_W-1:0]   num_out,
    output logic [cea_pkg::DEN_W-1:0]   den_out,
    output logic [cea_pkg::DEN_W-1:0]   rem_out,
    output logic [cea_pkg::QUO_W-1:0]   quo_out
);
    localparam int NW = cea_pkg::NUM_W;
    localparam int DW = cea_pkg::DEN_W;
    localparam int QW = cea_pkg::QUO_W;

    logic          dbit;
    logic [DW:0]   shifted;
    logic [DW-1:0] rem_next;
    logic          qbit;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;

    always_comb
    begin
        // below the numerator's bits the dividend is the zero fraction
        if (J < NW)
            dbit = num_in[(J < NW) ? (NW - 1 - J) : 0];
        else
            dbit = 1'b0;
        shifted = {rem_in, dbit};
        if (shifted >= {1'b0, den_in})
        begin
            rem_next = DW'(shifted - {1'b0, den_in});
            qbit     = 1'b1;
        end
        else
        begin
            rem_next = shifted[DW-1:0];
            qbit     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_in;
            den_reg <= den_in;
            rem_reg <= rem_next;
            quo_reg <= {quo_in[QW-2:0], qbit};
        end
    end

    assign num_out = num_reg;
    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

@@ rtl/core/cea_cordic_cell.sv @@
// One vectoring CORDIC rotation step with its registered x, y and angle.
module cea_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  logic              en,
    input  cea_pkg::cordic_t  cin,
    output cea_pkg::cordic_t  cout
);
    localparam int AW = cea_pkg::ANGLE_W;

    cea_pkg::cordic_t       cell_next;
    cea_pkg::cordic_t       cell_reg;
    logic signed [AW-1:0]   step;

    always_comb
    begin
        step      = $signed({5'd0, cea_pkg::atan_q16(5'(STAGE))});
        cell_next = cin;
        if (!cin.byp)
        begin
            if (!cin.y[cea_pkg::CORDIC_W-1])
            begin
                cell_next.x = cin.x + (cin.y >>> STAGE);
                cell_next.y = cin.y - (cin.x >>> STAGE);
                cell_next.z = cin.z + step;
            end
            else
            begin
                cell_next.x = cin.x - (cin.y >>> STAGE);
                cell_next.y = cin.y + (cin.x >>> STAGE);
                cell_next.z = cin.z - step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cell_reg <= cell_next;
    end

    assign cout = cell_reg;

endmodule

@@ rtl/core/cea_delay.sv @@
// Enabled shift line that keeps a side result in step with the longest path.
module cea_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < N; i++)
                tap_reg[i] <= tap_reg[i - 1];
        end
    end

    assign q = tap_reg[N - 1];

endmodule

@@ rtl/core/covariance_error_ellipse.sv @@
// Top level: covariance error ellipse pipeline, one item per cycle.
// Fully pipelined: a new item is taken every cycle while the output register
// is free or being read. The lateral path sets when the result is valid: six
// setup stages, a restoring divider of 63 + FRAC_BITS cells, a 32-cell square
// root and the scaling stage. The eigenvalue roots and the CORDIC yaw
// (CORDIC_STAGES cells) run alongside and are delayed to match. A stalled
// output freezes the whole pipeline. radius_scale is used directly and must
// only change while idle.
module covariance_error_ellipse #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [15:0]        cfg_write_data,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [31:0]        var_x,
    input  logic signed [31:0] cov_xy_upper,
    input  logic signed [31:0] cov_xy_lower,
    input  logic [31:0]        var_y,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [31:0]        major_radius,
    output logic [31:0]        minor_radius,
    output logic signed [14:0] major_axis_yaw,
    output logic [31:0]        lateral_extent,
    output logic               not_positive_definite
);
    localparam int SW     = cea_pkg::SQRT_W;
    localparam int SQ     = cea_pkg::SQRT_STEPS;
    localparam int CW     = cea_pkg::CORDIC_W;
    localparam int AW     = cea_pkg::ANGLE_W;
    localparam int NW     = cea_pkg::NUM_W;
    localparam int DNW    = cea_pkg::DEN_W;
    localparam int QW     = cea_pkg::QUO_W;
    localparam int YW     = cea_pkg::YAW_W;
    localparam int DIVN   = NW + FRAC_BITS;
    localparam int T_RT   = 2 + SQ;
    localparam int T_ROOT = T_RT + 1 + SQ;
    localparam int T_YAW  = 3 + CORDIC_STAGES;
    localparam int T_LAT  = 6 + DIVN + SQ;

    logic en;
    logic [T_LAT:1] vld_reg;
    logic           out_valid_reg;
    logic [15:0]    scale_reg;

    assign en         = !out_valid_reg || result_ready;
    assign item_ready = en;

    // ---------------- stage 1: products straight off the ports
    logic signed [32:0] diff_p1_next;
    logic [31:0]        hd_p1;
    logic [63:0]        hd2_p1_next;
    logic signed [63:0] b2_p1_next;
    logic [63:0]        ad_p1_next;
    logic [32:0]        s_p1_next;
    logic signed [32:0] sum_p1_next;
    logic signed [31:0] ww_p1_next, xx_p1_next, yy_p1_next, zz_p1_next;
    logic signed [31:0] xy_p1_next, wz_p1_next;

    logic signed [32:0] diff_p1_reg;
    logic [63:0]        hd2_p1_reg, b2_p1_reg, ad_p1_reg;
    logic [32:0]        s_p1_reg;
    logic signed [32:0] sum_p1_reg;
    logic signed [31:0] lo_p1_reg;
    logic [31:0]        a_p1_reg, d_p1_reg;
    logic signed [31:0] ww_p1_reg, xx_p1_reg, yy_p1_reg, zz_p1_reg;
    logic signed [31:0] xy_p1_reg, wz_p1_reg;

    always_comb
    begin
        diff_p1_next = $signed({1'b0, var_x}) - $signed({1'b0, var_y});
        hd_p1        = diff_p1_next[32] ? 32'(-diff_p1_next) : diff_p1_next[31:0];
        hd2_p1_next  = 64'(hd_p1) * 64'(hd_p1);
        b2_p1_next   = 64'(cov_xy_lower) * 64'(cov_xy_lower);
        ad_p1_next   = 64'(var_x) * 64'(var_y);
        s_p1_next    = {1'b0, var_x} + {1'b0, var_y};
        sum_p1_next  = 33'(cov_xy_upper) + 33'(cov_xy_lower);
        ww_p1_next   = 32'(quat_w) * 32'(quat_w);
        xx_p1_next   = 32'(quat_x) * 32'(quat_x);
        yy_p1_next   = 32'(quat_y) * 32'(quat_y);
        zz_p1_next   = 32'(quat_z) * 32'(quat_z);
        xy_p1_next   = 32'(quat_x) * 32'(quat_y);
        wz_p1_next   = 32'(quat_w) * 32'(quat_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_p1_reg <= diff_p1_next;
            hd2_p1_reg  <= hd2_p1_next;
            b2_p1_reg   <= b2_p1_next;
            ad_p1_reg   <= ad_p1_next;
            s_p1_reg    <= s_p1_next;
            sum_p1_reg  <= sum_p1_next;
            lo_p1_reg   <= cov_xy_lower;
            a_p1_reg    <= var_x;
            d_p1_reg    <= var_y;
            ww_p1_reg   <= ww_p1_next;
            xx_p1_reg   <= xx_p1_next;
            yy_p1_reg   <= yy_p1_next;
            zz_p1_reg   <= zz_p1_next;
            xy_p1_reg   <= xy_p1_next;
            wz_p1_reg   <= wz_p1_next;
        end
    end

    // ---------------- stage 2: eigen radicand, flag, heading, CORDIC start
    logic [63:0]        t_p2_next;
    logic               npd_p2_next;
    logic signed [33:0] vx_p2, vy_p2;  // full 16-bit quaternions reach 2^32
    logic [32:0]        ax_p2_next, ay_p2_next;
    logic signed [CW-1:0] cx0, cy0;
    cea_pkg::cordic_t   cord_p2_next;

    logic [63:0]        t_p2_reg;
    logic               npd_p2_reg;
    logic [32:0]        s_p2_reg;
    logic [32:0]        ax_p2_reg, ay_p2_reg;
    logic               nx_p2_reg, ny_p2_reg;
    logic [31:0]        a_p2_reg, d_p2_reg;
    logic signed [32:0] sum_p2_reg;
    cea_pkg::cordic_t   cord_p2_reg;

    always_comb
    begin
        t_p2_next   = {2'b00, hd2_p1_reg[63:2]} + b2_p1_reg;
        npd_p2_next = !(ad_p1_reg > b2_p1_reg);
        vx_p2       = 34'(ww_p1_reg) + 34'(xx_p1_reg) - 34'(yy_p1_reg) - 34'(zz_p1_reg);
        vy_p2       = (34'(xy_p1_reg) + 34'(wz_p1_reg)) <<< 1;
        ax_p2_next  = vx_p2[33] ? 33'(-vx_p2) : vx_p2[32:0];
        ay_p2_next  = vy_p2[33] ? 33'(-vy_p2) : vy_p2[32:0];

        cx0 = CW'(diff_p1_reg);
        cy0 = CW'(lo_p1_reg) <<< 1;
        cord_p2_next.x   = cx0;
        cord_p2_next.y   = cy0;
        cord_p2_next.z   = '0;
        cord_p2_next.byp = 1'b0;
        if (lo_p1_reg == 32'sd0)
        begin
            cord_p2_next.byp = 1'b1;
            cord_p2_next.z   = diff_p1_reg[32] ? cea_pkg::PI_Q16 : '0;
        end
        else if (diff_p1_reg[32])
        begin
            // left half plane: rotate by pi first
            cord_p2_next.z = lo_p1_reg[31] ? -cea_pkg::PI_Q16 : cea_pkg::PI_Q16;
            cord_p2_next.x = -cx0;
            cord_p2_next.y = -cy0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_p2_reg    <= t_p2_next;
            npd_p2_reg  <= npd_p2_next;
            s_p2_reg    <= s_p1_reg;
            ax_p2_reg   <= ax_p2_next;
            ay_p2_reg   <= ay_p2_next;
            nx_p2_reg   <= vx_p2[33];
            ny_p2_reg   <= vy_p2[33];
            a_p2_reg    <= a_p1_reg;
            d_p2_reg    <= d_p1_reg;
            sum_p2_reg  <= sum_p1_reg;
            cord_p2_reg <= cord_p2_next;
        end
    end

    // ---------------- stage 3: shift heading below 2^14
    logic [32:0]        mx_p3;
    logic [4:0]         k_p3;
    logic [32:0]        xm_p3, ym_p3;
    logic signed [14:0] xs_p3_next, ys_p3_next;

    logic signed [14:0] xs_p3_reg, ys_p3_reg;
    logic [31:0]        a_p3_reg, d_p3_reg;
    logic signed [32:0] sum_p3_reg;

    always_comb
    begin
        mx_p3 = (ax_p2_reg > ay_p2_reg) ? ax_p2_reg : ay_p2_reg;
        k_p3  = '0;
        for (int i = 14; i < 33; i++)
        begin
            if (mx_p3[i])
                k_p3 = 5'(i - 13);
        end
        xm_p3 = ax_p2_reg >> k_p3;
        ym_p3 = ay_p2_reg >> k_p3;
        if (ax_p2_reg == '0 && ay_p2_reg == '0)
        begin
            xs_p3_next = 15'sd1;
            ys_p3_next = 15'sd0;
        end
        else
        begin
            xs_p3_next = nx_p2_reg ? -$signed({1'b0, xm_p3[13:0]})
                                   : $signed({1'b0, xm_p3[13:0]});
            ys_p3_next = ny_p2_reg ? -$signed({1'b0, ym_p3[13:0]})
                                   : $signed({1'b0, ym_p3[13:0]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs_p3_reg  <= xs_p3_next;
            ys_p3_reg  <= ys_p3_next;
            a_p3_reg   <= a_p2_reg;
            d_p3_reg   <= d_p2_reg;
            sum_p3_reg <= sum_p2_reg;
        end
    end

    // ---------------- stage 4: squares of the heading
    logic signed [29:0] xs2_p4, ys2_p4, xys_p4;
    logic [DNW-1:0]     den_p4_next;

    logic [27:0]        xs2_p4_reg, ys2_p4_reg;
    logic signed [28:0] xys_p4_reg;
    logic [DNW-1:0]     den_p4_reg;
    logic [31:0]        a_p4_reg, d_p4_reg;
    logic signed [32:0] sum_p4_reg;

    always_comb
    begin
        xs2_p4      = 30'(xs_p3_reg) * 30'(xs_p3_reg);
        ys2_p4      = 30'(ys_p3_reg) * 30'(ys_p3_reg);
        xys_p4      = 30'(xs_p3_reg) * 30'(ys_p3_reg);
        den_p4_next = {1'b0, xs2_p4[27:0]} + {1'b0, ys2_p4[27:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs2_p4_reg <= xs2_p4[27:0];
            ys2_p4_reg <= ys2_p4[27:0];
            xys_p4_reg <= xys_p4[28:0];
            den_p4_reg <= den_p4_next;
            a_p4_reg   <= a_p3_reg;
            d_p4_reg   <= d_p3_reg;
            sum_p4_reg <= sum_p3_reg;
        end
    end

    // ---------------- stage 5: quadratic form terms
    logic [59:0]        ta_p5_reg, td_p5_reg;
    logic signed [61:0] tc_p5_reg;
    logic [DNW-1:0]     den_p5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_p5_reg  <= 60'(a_p4_reg) * 60'(ys2_p4_reg);
            td_p5_reg  <= 60'(d_p4_reg) * 60'(xs2_p4_reg);
            tc_p5_reg  <= 62'(sum_p4_reg) * 62'(xys_p4_reg);
            den_p5_reg <= den_p4_reg;
        end
    end

    // ---------------- stage 6: numerator, zero when not positive or denominator zero
    logic signed [63:0] num_p6;
    logic [NW-1:0]      num_p6_next;
    logic [NW-1:0]      num_p6_reg;
    logic [DNW-1:0]     den_p6_reg;

    always_comb
    begin
        num_p6 = $signed({4'b0, ta_p5_reg}) + $signed({4'b0, td_p5_reg})
               - 64'(tc_p5_reg);
        if (!num_p6[63] && num_p6 != 64'sd0 && den_p5_reg != '0)
            num_p6_next = num_p6[NW-1:0];
        else
            num_p6_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_p6_reg <= num_p6_next;
            den_p6_reg <= den_p5_reg;
        end
    end

    // ---------------- lateral: divider cells then square root cells
    logic [NW-1:0]  dnum [DIVN+1];
    logic [DNW-1:0] dden [DIVN+1];
    logic [DNW-1:0] drem [DIVN+1];
    logic [QW-1:0]  dquo [DIVN+1];

    assign dnum[0] = num_p6_reg;
    assign dden[0] = den_p6_reg;
    assign drem[0] = '0;
    assign dquo[0] = '0;

    for (genvar j = 0; j < DIVN; j++)
    begin : g_div
        cea_div_cell #(.J(j)) u_cell (
            .clk     (clk),
            .en      (en),
            .num_in  (dnum[j]),
            .den_in  (dden[j]),
            .rem_in  (drem[j]),
            .quo_in  (dquo[j]),
            .num_out (dnum[j + 1]),
            .den_out (dden[j + 1]),
            .rem_out (drem[j + 1]),
            .quo_out (dquo[j + 1])
        );
    end

    logic [SW-1:0] lrad [SQ+1];
    logic [SW-1:0] lroot [SQ+1];
    assign lrad[0]  = dquo[DIVN];
    assign lroot[0] = '0;

    for (genvar i = 0; i < SQ; i++)
    begin : g_lat_sqrt
        cea_sqrt_cell #(.STEP(i)) u_cell (
            .clk      (clk),
            .en       (en),
            .rad_in   (lrad[i]),
            .root_in  (lroot[i]),
            .rad_out  (lrad[i + 1]),
            .root_out (lroot[i + 1])
        );
    end

    // ---------------- eigen: r = isqrt(((a-d)^2)/4 + b^2)
    logic [SW-1:0] trad [SQ+1];
    logic [SW-1:0] troot [SQ+1];
    assign trad[0]  = t_p2_reg;
    assign troot[0] = '0;

    for (genvar i = 0; i < SQ; i++)
    begin : g_r_sqrt
        cea_sqrt_cell #(.STEP(i)) u_cell (
            .clk      (clk),
            .en       (en),
            .rad_in   (trad[i]),
            .root_in  (troot[i]),
            .rad_out  (trad[i + 1]),
            .root_out (troot[i + 1])
        );
    end

    logic [32:0] s_rt;
    cea_delay #(.W(33), .N(SQ)) u_s_dly (
        .clk (clk),
        .en  (en),
        .d   (s_p2_reg),
        .q   (s_rt)
    );

    // twice the eigenvalues, then shifted radicands
    logic [34:0]        l1_e;
    logic signed [35:0] l0_e;
    logic [SW-1:0]      maj_e_next, min_e_next;
    logic [SW-1:0]      maj_e_reg, min_e_reg;

    always_comb
    begin
        l1_e       = 35'(s_rt) + 35'({troot[SQ][31:0], 1'b0});
        l0_e       = $signed(36'(s_rt)) - $signed(36'({troot[SQ][31:0], 1'b0}));
        maj_e_next = SW'(l1_e) << (FRAC_BITS - 1);
        if (!l0_e[35] && l0_e != 36'sd0)
            min_e_next = SW'(l0_e[34:0]) << (FRAC_BITS - 1);
        else
            min_e_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            maj_e_reg <= maj_e_next;
            min_e_reg <= min_e_next;
        end
    end

    logic [SW-1:0] mjrad [SQ+1];
    logic [SW-1:0] mjroot [SQ+1];
    logic [SW-1:0] mnrad [SQ+1];
    logic [SW-1:0] mnroot [SQ+1];
    assign mjrad[0]  = maj_e_reg;
    assign mjroot[0] = '0;
    assign mnrad[0]  = min_e_reg;
    assign mnroot[0] = '0;

    for (genvar i = 0; i < SQ; i++)
    begin : g_eig_sqrt
        cea_sqrt_cell #(.STEP(i)) u_major (
            .clk      (clk),
            .en       (en),
            .rad_in   (mjrad[i]),
            .root_in  (mjroot[i]),
            .rad_out  (mjrad[i + 1]),
            .root_out (mjroot[i + 1])
        );
        cea_sqrt_cell #(.STEP(i)) u_minor (
            .clk      (clk),
            .en       (en),
            .rad_in   (mnrad[i]),
            .root_in  (mnroot[i]),
            .rad_out  (mnrad[i + 1]),
            .root_out (mnroot[i + 1])
        );
    end

    logic [63:0] roots_al;
    cea_delay #(.W(64), .N(T_LAT - T_ROOT)) u_root_dly (
        .clk (clk),
        .en  (en),
        .d   ({mjroot[SQ][31:0], mnroot[SQ][31:0]}),
        .q   (roots_al)
    );

    // ---------------- yaw: CORDIC cells, then halve and round
    cea_pkg::cordic_t cst [CORDIC_STAGES+1];
    assign cst[0] = cord_p2_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        cea_cordic_cell #(.STAGE(i)) u_cell (
            .clk  (clk),
            .en   (en),
            .cin  (cst[i]),
            .cout (cst[i + 1])
        );
    end

    logic signed [AW-1:0] yaw_r;
    logic signed [YW-1:0] yaw_next;
    logic signed [YW-1:0] yaw_reg;
    logic signed [YW-1:0] yaw_al;

    always_comb
    begin
        yaw_r = (cst[CORDIC_STAGES].z + 21'sd8) >>> 4;
        if (yaw_r > cea_pkg::YAW_LIMIT)
            yaw_next = YW'(cea_pkg::YAW_LIMIT);
        else if (yaw_r < -cea_pkg::YAW_LIMIT)
            yaw_next = YW'(-cea_pkg::YAW_LIMIT);
        else
            yaw_next = yaw_r[YW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            yaw_reg <= yaw_next;
    end

    cea_delay #(.W(YW), .N(T_LAT - T_YAW)) u_yaw_dly (
        .clk (clk),
        .en  (en),
        .d   (yaw_reg),
        .q   (yaw_al)
    );

    logic npd_al;
    cea_delay #(.W(1), .N(T_LAT - 2)) u_npd_dly (
        .clk (clk),
        .en  (en),
        .d   (npd_p2_reg),
        .q   (npd_al)
    );

    // ---------------- scaling and output register
    function automatic logic [31:0] scale_sat(input logic [31:0] root,
                                              input logic [15:0] scale);
        logic [47:0] prod;
        prod = 48'(root) * 48'(scale);
        return (prod[47:40] != '0) ? '1 : prod[39:8];
    endfunction

    logic [31:0]        major_reg, minor_reg, lateral_reg;
    logic signed [14:0] yaw_out_reg;
    logic               npd_out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            major_reg   <= scale_sat(roots_al[63:32], scale_reg);
            minor_reg   <= scale_sat(roots_al[31:0], scale_reg);
            lateral_reg <= scale_sat(lroot[SQ][31:0], scale_reg);
            yaw_out_reg <= yaw_al;
            npd_out_reg <= npd_al;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            scale_reg     <= 16'd256;
        end
        else
        begin
            if (cfg_write_en)
                scale_reg <= cfg_write_data;
            if (en)
            begin
                vld_reg       <= {vld_reg[T_LAT-1:1], item_valid};
                out_valid_reg <= vld_reg[T_LAT];
            end
        end
    end

    assign result_valid          = out_valid_reg;
    assign major_radius          = major_reg;
    assign minor_radius          = minor_reg;
    assign major_axis_yaw        = yaw_out_reg;
    assign lateral_extent        = lateral_reg;
    assign not_positive_definite = npd_out_reg;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !item_ready)
        else $error("input taken while output stalled");

    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> vld_reg[1])
        else $error("accepted item missing from stage one");

    a_minor_le_major: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> minor_radius <= major_radius)
        else $error("minor radius exceeds major radius");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (major_axis_yaw <= 15'sd12868 && major_axis_yaw >= -15'sd12868))
        else $error("yaw outside half-turn range");

    a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

@@ tb/tb_covariance_error_ellipse.sv @@
// Self-checking testbench for the covariance error ellipse pipeline.
module tb_covariance_error_ellipse;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC      = 16;
    localparam int  STAGES    = 16;
    localparam int  LATENCY   = 101 + FRAC;
    localparam int  MAX_CYCLE = 600000;
    localparam longint YAW_MAX = 12868;
    localparam longint PI_RAD  = 205887;
    localparam longint ALL_ONES = 64'h0000_0000_FFFF_FFFF;

    typedef struct {
        logic [31:0]        major;
        logic [31:0]        minor;
        logic signed [14:0] yaw;
        logic [31:0]        lateral;
        logic               npd;
    } ellipse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [15:0] cfg_write_data = '0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic [31:0] var_x = '0;
    logic signed [31:0] cov_xy_upper = '0;
    logic signed [31:0] cov_xy_lower = '0;
    logic [31:0] var_y = '0;
    logic signed [15:0] quat_x = '0;
    logic signed [15:0] quat_y = '0;
    logic signed [15:0] quat_z = '0;
    logic signed [15:0] quat_w = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [31:0] major_radius;
    logic [31:0] minor_radius;
    logic signed [14:0] major_axis_yaw;
    logic [31:0] lateral_extent;
    logic not_positive_definite;

    ellipse_t pending_ellipses[$];
    longint unsigned scale_q8 = 256;
    int errors = 0;
    int cycles = 0;
    bit stall_enable = 1'b1;
    int stall_left = 0;
    longint atan_tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2, 1};

    covariance_error_ellipse #(.CORDIC_STAGES(STAGES), .FRAC_BITS(FRAC)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .item_valid(item_valid), .item_ready(item_ready),
        .var_x(var_x), .cov_xy_upper(cov_xy_upper), .cov_xy_lower(cov_xy_lower),
        .var_y(var_y), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .quat_w(quat_w),
        .result_valid(result_valid), .result_ready(result_ready),
        .major_radius(major_radius), .minor_radius(minor_radius),
        .major_axis_yaw(major_axis_yaw), .lateral_extent(lateral_extent),
        .not_positive_definite(not_positive_definite)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] apply_scale(input longint unsigned root);
        longint unsigned v;
        v = (root * scale_q8) >> 8;
        return (v > ALL_ONES) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // atan2(y, x) in 2^-16 rad
    function automatic longint cordic_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (y == 0)
            return (x < 0) ? PI_RAD : 0;
        if (x < 0) begin
            z = (y > 0) ? PI_RAD : -PI_RAD;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += (i < 17) ? atan_tab[i] : 0;
            end else begin
                x -= dx;
                y += dy;
                z -= (i < 17) ? atan_tab[i] : 0;
            end
        end
        return z;
    endfunction

    function automatic ellipse_t predict_ellipse(
        input logic [31:0] vx_in, input logic signed [31:0] up_in,
        input logic signed [31:0] lo_in, input logic [31:0] vy_in,
        input logic signed [15:0] qx_in, input logic signed [15:0] qy_in,
        input logic signed [15:0] qz_in, input logic signed [15:0] qw_in);
        ellipse_t e;
        longint a, d, up, lo, diff, l0, yawv, dirx, diry, xs, ys, num, den;
        longint qx, qy, qz, qw;
        longint unsigned hd, b2, r, s, l1, ax, ay, mx, lat, q, rem;
        int k;
        a = longint'(vx_in);
        d = longint'(vy_in);
        up = longint'(up_in);
        lo = longint'(lo_in);
        qx = longint'(qx_in);
        qy = longint'(qy_in);
        qz = longint'(qz_in);
        qw = longint'(qw_in);
        diff = a - d;
        hd = (diff < 0) ? -diff : diff;
        b2 = lo * lo;
        r = floor_sqrt(((hd * hd) >> 2) + b2);
        s = a + d;
        l1 = s + 2 * r;
        e.major = apply_scale(floor_sqrt(l1 << (FRAC - 1)));
        l0 = longint'(s) - 2 * longint'(r);
        e.minor = (l0 > 0) ? apply_scale(floor_sqrt(longint'(l0) << (FRAC - 1))) : '0;
        yawv = (cordic_angle(diff, 2 * lo) + 8) >>> 4;
        if (yawv > YAW_MAX) yawv = YAW_MAX;
        if (yawv < -YAW_MAX) yawv = -YAW_MAX;
        e.yaw = yawv[14:0];
        dirx = qw * qw + qx * qx - qy * qy - qz * qz;
        diry = 2 * (qx * qy + qw * qz);
        ax = (dirx < 0) ? -dirx : dirx;
        ay = (diry < 0) ? -diry : diry;
        if (ax == 0 && ay == 0) begin
            xs = 1;
            ys = 0;
        end else begin
            mx = (ax > ay) ? ax : ay;
            k = 0;
            while ((mx >> k) >= (64'd1 << 14))
                k++;
            xs = longint'(ax >> k);
            ys = longint'(ay >> k);
            if (dirx < 0) xs = -xs;
            if (diry < 0) ys = -ys;
        end
        num = a * (ys * ys) + d * (xs * xs) - (up + lo) * (xs * ys);
        den = xs * xs + ys * ys;
        lat = 0;
        if (num > 0 && den > 0) begin
            q = num / den;
            rem = num % den;
            lat = (q << FRAC) + ((rem << FRAC) / longint'(den));
        end
        e.lateral = apply_scale(floor_sqrt(lat));
        e.npd = (longint'(vx_in) * longint'(vy_in) > b2) ? 1'b0 : 1'b1;
        return e;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_pose(
        input logic [31:0] vx_in, input logic signed [31:0] up_in,
        input logic signed [31:0] lo_in, input logic [31:0] vy_in,
        input logic signed [15:0] qx_in, input logic signed [15:0] qy_in,
        input logic signed [15:0] qz_in, input logic signed [15:0] qw_in);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        var_x = vx_in;
        cov_xy_upper = up_in;
        cov_xy_lower = lo_in;
        var_y = vy_in;
        quat_x = qx_in;
        quat_y = qy_in;
        quat_z = qz_in;
        quat_w = qw_in;
        item_valid = 1'b1;
        do @(posedge clk); while (!item_ready);
        pending_ellipses.push_back(predict_ellipse(vx_in, up_in, lo_in, vy_in,
                                                   qx_in, qy_in, qz_in, qw_in));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_ellipses.size() != 0) @(negedge clk);
        repeat (LATENCY + 20) @(negedge clk);
    endtask

    task automatic set_radius_scale(input logic [15:0] value);
        wait_idle();
        cfg_write_en = 1'b1;
        cfg_write_data = value;
        @(negedge clk);
        cfg_write_en = 1'b0;
        scale_q8 = value;
    endtask

    function automatic logic signed [15:0] rand_quat();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    task automatic test_directed();
        send_pose('0, '0, '0, '0, '0, '0, '0, 16'sd16384);
        send_pose('1, '0, '0, '1, '0, '0, '0, 16'sd16384);
        send_pose('1, '0, '0, '0, '0, '0, 16'sd16384, '0);
        send_pose('0, '0, '0, '1, '0, '0, '0, 16'sd16384);
        send_pose(32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65536,
                  16'sd11585, '0, '0, 16'sd11585);
        send_pose(32'd65536, 32'sh8000_0000, 32'sh8000_0000, 32'd65536,
                  '0, '0, -16'sd16384, 16'sd16384);
        // equal variances, no correlation
        send_pose(32'd200000, '0, '0, 32'd200000, '0, '0, '0, 16'sd16384);
        // var_y larger, no correlation: yaw pi/2
        send_pose(32'd1000, '0, '0, 32'd900000, '0, '0, '0, 16'sd16384);
        // positive definite with correlation
        send_pose(32'd400000, 32'sd100000, 32'sd100000, 32'd300000,
                  16'sd2000, -16'sd3000, 16'sd8000, 16'sd13000);
        // singular matrix
        send_pose(32'd65536, 32'sd65536, 32'sd65536, 32'd65536,
                  '0, '0, '0, 16'sd16384);
        // negative lateral form
        send_pose('0, 32'sd500000, 32'sd500000, '0, '0, '0, 16'sd6270, 16'sd15137);
        // zero direction
        send_pose(32'd70000, 32'sd10, -32'sd10, 32'd50000, '0, '0, '0, '0);
        // pitch at ninety degrees
        send_pose(32'd70000, 32'sd1000, 32'sd1000, 32'd50000,
                  '0, 16'sd11585, '0, 16'sd11585);
        send_pose(32'd123456, -32'sd40000, 32'sd40000, 32'd654321,
                  -16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384);
        send_pose(32'hDEAD_BEEF, 32'sh1234_5678, -32'sd777, 32'h0000_0001,
                  16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384);
        send_pose('0, -32'sd1, -32'sd1, '0, 16'sd1, 16'sd1, -16'sd1, -16'sd1);
        // quaternion components at the ends of the 16-bit range
        send_pose(32'd90000, 32'sd300, 32'sd200, 32'd40000,
                  -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_pose(32'd90000, -32'sd5000, 32'sd7000, 32'd40000,
                  -16'sd32768, '0, '0, -16'sd32768);
        send_pose(32'd5000, 32'sd900, 32'sd900, 32'd80000,
                  16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767);
    endtask

    task automatic test_random(input int count);
        logic [31:0] a, d;
        logic signed [31:0] up, lo;
        longint lim;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            a = $urandom;
            d = $urandom;
            up = $urandom;
            lo = $urandom;
            if (kind < 70) begin
                // mostly well-formed covariance with |b| no larger than sqrt(a*d)
                a = $urandom_range(1 << $urandom_range(4, 24));
                d = $urandom_range(1 << $urandom_range(4, 24));
                lim = floor_sqrt(longint'(a) * longint'(d));
                lo = 32'(longint'($urandom_range(32'(2 * lim))) - lim);
                up = ($urandom_range(3) == 0) ? 32'($urandom) : lo;
            end else if (kind < 80) begin
                up = lo;
                if ($urandom_range(1)) lo = '0;
            end
            send_pose(a, up, lo, d, rand_quat(), rand_quat(), rand_quat(), rand_quat());
        end
    endtask

    task automatic test_scale_settings();
        set_radius_scale(16'd0);
        test_random(150);
        set_radius_scale(16'hFFFF);
        test_random(200);
        set_radius_scale(16'd1);
        test_random(150);
        set_radius_scale(16'($urandom));
        stall_enable = 1'b0;
        test_random(150);
        stall_enable = 1'b1;
        set_radius_scale(16'd256);
        test_random(100);
    endtask

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            result_ready <= 1'b0;
        end else if (stall_enable && $urandom_range(99) < 20) begin
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 2);
            result_ready <= 1'b0;
        end else begin
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        ellipse_t exp_e;
        if (rst_n && result_valid && result_ready) begin
            if (pending_ellipses.size() == 0) begin
                $display("%0t: unexpected result", $time);
                errors++;
            end else begin
                exp_e = pending_ellipses.pop_front();
                if (major_radius !== exp_e.major) begin
                    $display("%0t: major_radius exp %h got %h", $time, exp_e.major,
                             major_radius);
                    errors++;
                end
                if (minor_radius !== exp_e.minor) begin
                    $display("%0t: minor_radius exp %h got %h", $time, exp_e.minor,
                             minor_radius);
                    errors++;
                end
                if (major_axis_yaw !== exp_e.yaw) begin
                    $display("%0t: major_axis_yaw exp %0d got %0d", $time, exp_e.yaw,
                             major_axis_yaw);
                    errors++;
                end
                if (lateral_extent !== exp_e.lateral) begin
                    $display("%0t: lateral_extent exp %h got %h", $time, exp_e.lateral,
                             lateral_extent);
                    errors++;
                end
                if (not_positive_definite !== exp_e.npd) begin
                    $display("%0t: not_positive_definite exp %b got %b", $time,
                             exp_e.npd, not_positive_definite);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(300);
        test_scale_settings();
        wait_idle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
